FILE: rtl/ptk_pkg.sv
`timescale 1ns / 1ps

package ptk_pkg;

  // list geometry
  localparam int ENTRIES_PER_LIST = 10;
  localparam int LIST_COUNT       = 3;
  localparam int HARD_LIST_LIMIT  = 3;

  // field widths
  localparam int ACTION_W   = 2;
  localparam int SCORE_W    = 31;
  localparam int LIST_SEL_W = 2;
  localparam int TAG_W      = 24;
  localparam int POS_W      = 4;

  localparam int ENTRY_IDX_W = $clog2(ENTRIES_PER_LIST);
  localparam int LIST_IDX_W  = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_CHECK  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_READ   = 2'd2,
    ACT_UNUSED = 2'd3
  } action_t;

  // classified command as the back end sees it
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_CHECK,
    CMD_INSERT,
    CMD_READ,
    CMD_READ_MISS
  } cmd_t;

  typedef struct packed {
    cmd_t                   cmd;
    logic [LIST_IDX_W-1:0]  list_idx;
    logic [SCORE_W-1:0]     score;
    logic [TAG_W-1:0]       tag;
    logic [POS_W-1:0]       read_index;
  } cmd_item_t;

  // queue head as offered to the back end
  typedef struct packed {
    logic      valid;
    cmd_item_t item;
  } queue_head_t;

endpackage

FILE: rtl/ptk_front.sv
`timescale 1ns / 1ps

module ptk_front (
  input  logic                          start,
  input  logic [ptk_pkg::ACTION_W-1:0]   action,
  input  logic [ptk_pkg::SCORE_W-1:0]    score,
  input  logic [ptk_pkg::LIST_SEL_W-1:0] list_sel,
  input  logic [ptk_pkg::TAG_W-1:0]      tag,
  input  logic [ptk_pkg::POS_W-1:0]      read_index,
  input  logic                          queue_full,
  input  logic                          rst,
  output logic                          busy,
  output logic                          push,
  output ptk_pkg::cmd_item_t            push_item
);
  import ptk_pkg::*;

  logic list_ok;
  logic index_ok;

  always_comb begin
    list_ok  = ({1'b0, list_sel} < 3'(HARD_LIST_LIMIT)) &&
               ({1'b0, list_sel} < 3'(LIST_COUNT));
    index_ok = ({1'b0, read_index} < 5'(ENTRIES_PER_LIST));

    busy = rst || queue_full;
    push = start && !busy;

    push_item.list_idx   = list_sel[LIST_IDX_W-1:0];
    push_item.score      = score;
    push_item.tag        = tag;
    push_item.read_index = read_index;

    case (action_t'(action))
      ACT_CHECK:  push_item.cmd = list_ok ? CMD_CHECK : CMD_NOP;
      ACT_INSERT: push_item.cmd = list_ok ? CMD_INSERT : CMD_NOP;
      ACT_READ:   push_item.cmd = (list_ok && index_ok) ? CMD_READ : CMD_READ_MISS;
      default:    push_item.cmd = CMD_NOP;
    endcase
  end

endmodule

FILE: rtl/ptk_queue.sv
`timescale 1ns / 1ps

module ptk_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ptk_pkg::cmd_item_t   push_item,
  input  logic                 pop,
  output logic                 full,
  output ptk_pkg::queue_head_t head
);
  import ptk_pkg::*;

  cmd_item_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign do_pop     = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(do_pop);
    end
  end

endmodule

FILE: rtl/ptk_back.sv
`timescale 1ns / 1ps

module ptk_back (
  input  logic                          clk,
  input  logic                          rst,
  input  ptk_pkg::queue_head_t          head,
  output logic                          pop,
  output logic                          done,
  output logic                          found,
  output logic [ptk_pkg::POS_W-1:0]     position,
  output logic [ptk_pkg::SCORE_W-1:0]   entry_score,
  output logic [ptk_pkg::TAG_W-1:0]     entry_tag
);
  import ptk_pkg::*;

  logic [SCORE_W-1:0] score_q [LIST_COUNT][ENTRIES_PER_LIST];
  logic [TAG_W-1:0]   tag_q   [LIST_COUNT][ENTRIES_PER_LIST];

  cmd_item_t                    item;
  logic [ENTRIES_PER_LIST-1:0]  beats;
  logic [ENTRIES_PER_LIST-1:0]  first_hit;
  logic [ENTRIES_PER_LIST-1:0]  below_hit;
  logic                         seen;
  logic                         hit;
  logic [POS_W-1:0]             hit_pos;
  logic                         do_insert;

  logic                         found_next;
  logic [POS_W-1:0]             position_next;
  logic [SCORE_W-1:0]           entry_score_next;
  logic [TAG_W-1:0]             entry_tag_next;

  assign item      = head.item;
  assign pop       = head.valid;
  assign do_insert = head.valid && (item.cmd == CMD_INSERT) && hit;

  // compare row: every cell of the selected list against the new score
  always_comb begin
    seen    = 1'b0;
    hit_pos = '0;
    for (int i = 0; i < ENTRIES_PER_LIST; i++) begin
      beats[i]     = item.score > score_q[item.list_idx][i];
      below_hit[i] = seen;
      first_hit[i] = beats[i] && !seen;
      if (first_hit[i]) begin
        hit_pos = POS_W'(i);
      end
      seen = seen || beats[i];
    end
    hit = seen;
  end

  always_comb begin
    found_next       = 1'b0;
    position_next    = '0;
    entry_score_next = '0;
    entry_tag_next   = '0;
    case (item.cmd)
      CMD_CHECK, CMD_INSERT: begin
        found_next    = hit;
        position_next = hit ? hit_pos : '0;
      end
      CMD_READ: begin
        found_next       = 1'b1;
        position_next    = item.read_index;
        entry_score_next = score_q[item.list_idx][item.read_index[ENTRY_IDX_W-1:0]];
        entry_tag_next   = tag_q[item.list_idx][item.read_index[ENTRY_IDX_W-1:0]];
      end
      CMD_READ_MISS: begin
        position_next = item.read_index;
      end
      default: begin
        found_next = 1'b0;
      end
    endcase
  end

  // shift cells below the hit down by one, write the new entry at the hit
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < LIST_COUNT; l++) begin
        for (int i = 0; i < ENTRIES_PER_LIST; i++) begin
          score_q[l][i] <= '0;
          tag_q[l][i]   <= '0;
        end
      end
    end else if (do_insert) begin
      for (int l = 0; l < LIST_COUNT; l++) begin
        if (item.list_idx == LIST_IDX_W'(l)) begin
          for (int i = 0; i < ENTRIES_PER_LIST; i++) begin
            if (first_hit[i]) begin
              score_q[l][i] <= item.score;
              tag_q[l][i]   <= item.tag;
            end else if (below_hit[i] && (i > 0)) begin
              score_q[l][i] <= score_q[l][(i > 0) ? i - 1 : 0];
              tag_q[l][i]   <= tag_q[l][(i > 0) ? i - 1 : 0];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (head.valid) begin
      found       <= found_next;
      position    <= position_next;
      entry_score <= entry_score_next;
      entry_tag   <= entry_tag_next;
    end
  end

endmodule

FILE: rtl/partitioned_top_k_table.sv
`timescale 1ns / 1ps

// partitioned top-k table: keeps LIST_COUNT descending-sorted lists of
// ENTRIES_PER_LIST score/tag entries, all zero after reset. an item is taken
// at a clock edge where start is high and busy is low; its result is driven
// on found/position/entry_score/entry_tag from the next clock edge, marked by
// done for exactly one cycle, and is taken at the edge after that. it must be
// captured then since the receiver cannot hold it off.
// one item per cycle is sustained: the back end settles each item at the edge
// of its pop, where one compare cell per entry of the chosen list works in
// parallel and the list shifts in place. busy is high during reset; otherwise
// it would only rise with the two-entry command queue full, which never
// happens since the back end drains one command every cycle.
module partitioned_top_k_table (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [ptk_pkg::ACTION_W-1:0]   action,
  input  logic [ptk_pkg::SCORE_W-1:0]    score,
  input  logic [ptk_pkg::LIST_SEL_W-1:0] list_sel,
  input  logic [ptk_pkg::TAG_W-1:0]      tag,
  input  logic [ptk_pkg::POS_W-1:0]      read_index,
  output logic                           done,
  output logic                           found,
  output logic [ptk_pkg::POS_W-1:0]      position,
  output logic [ptk_pkg::SCORE_W-1:0]    entry_score,
  output logic [ptk_pkg::TAG_W-1:0]      entry_tag
);
  import ptk_pkg::*;

  logic        push;
  cmd_item_t   push_item;
  logic        queue_full;
  logic        pop;
  queue_head_t head;

  // front: takes the item, checks list and index, turns action into a command
  ptk_front u_front (
    .start      (start),
    .action     (action),
    .score      (score),
    .list_sel   (list_sel),
    .tag        (tag),
    .read_index (read_index),
    .queue_full (queue_full),
    .rst        (rst),
    .busy       (busy),
    .push       (push),
    .push_item  (push_item)
  );

  // short queue decoupling the front from the back
  ptk_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (queue_full),
    .head      (head)
  );

  // back: rank search, in-place insert and entry read, registered result
  ptk_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .done        (done),
    .found       (found),
    .position    (position),
    .entry_score (entry_score),
    .entry_tag   (entry_tag)
  );

endmodule

FILE: rtl/ptk_checker.sv
`timescale 1ns / 1ps

module ptk_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic                         found,
  input logic [ptk_pkg::SCORE_W-1:0]  entry_score,
  input logic [ptk_pkg::TAG_W-1:0]    entry_tag
);
  import ptk_pkg::*;

  // every accepted item gives its result through the queue slot and the result register
  a_item_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted item produced no result");

  // no result without an item accepted ahead of it through the queue and the result register
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without accepted item");

  // entry data only comes with a successful read
  a_entry_needs_found: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (entry_score == '0 && entry_tag == '0))
    else $error("entry data on a miss");

  // the queue never fills when results drain every cycle
  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !busy)
    else $error("busy raised outside reset");

endmodule

bind partitioned_top_k_table ptk_checker u_ptk_checker (.*);
